FILE: hw/rtl/gsa_pkg.sv
package gsa_pkg;

   // default sizes of the handle table
   localparam int SLOTS_DEF    = 1024;
   localparam int GEN_BITS_DEF = 16;

   // fixed field widths of the channels
   localparam int CMD_W        = 2;
   localparam int SLOT_FIELD_W = 10;
   localparam int GEN_FIELD_W  = 16;
   localparam int STATUS_W     = 2;
   localparam int REV_W        = 32;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_SPAWN   = 2'd0,
      CMD_DESPAWN = 2'd1,
      CMD_CHECK   = 2'd2
   } gsa_cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ASSET = 2'd1,
      ST_FULL      = 2'd2,
      ST_STALE     = 2'd3
   } gsa_status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_STACK,
      S_TABLE,
      S_REPLY
   } gsa_state_type;

   // request payload
   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic                    asset_valid;
      logic [SLOT_FIELD_W-1:0] handle_slot;
      logic [GEN_FIELD_W-1:0]  handle_generation;
   } gsa_req_type;

   // response payload
   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_FIELD_W-1:0] slot_out;
      logic [GEN_FIELD_W-1:0]  generation_out;
      logic [REV_W-1:0]        revision;
   } gsa_rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic           req_ready;
      logic           stack_pop;
      logic           tbl_rd_handle;
      logic           tbl_rd_stack;
      logic           spawn_new;
      logic           spawn_reuse;
      logic           release_slot;
      logic           set_result;
      gsa_status_type res_code;
      logic           out_load;
   } gsa_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic             req_valid;
      logic [CMD_W-1:0] command;
      logic             asset_valid;
      logic             stack_empty;
      logic             table_full;
      logic             in_range;
      logic             handle_match;
      logic             out_free;
   } gsa_stat_type;

endpackage

FILE: hw/rtl/gsa_req_if.sv
interface gsa_req_if;
   import gsa_pkg::*;

   logic        valid;
   logic        ready;
   gsa_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/gsa_rsp_if.sv
interface gsa_rsp_if;
   import gsa_pkg::*;

   logic        valid;
   logic        ready;
   gsa_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/gsa_controller.sv
module gsa_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  gsa_pkg::gsa_stat_type stat,
   output gsa_pkg::gsa_ctrl_type ctrl
);
   import gsa_pkg::*;

   gsa_state_type state_ff;
   gsa_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (stat.req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.command)
               CMD_SPAWN: begin
                  if (stat.asset_valid && !stat.stack_empty) begin
                     state_in = S_STACK;
                  end else begin
                     state_in = S_REPLY;
                  end
               end
               CMD_DESPAWN, CMD_CHECK: begin
                  state_in = stat.in_range ? S_TABLE : S_REPLY;
               end
               default: state_in = S_REPLY;
            endcase
         end
         S_STACK: state_in = S_TABLE;
         S_TABLE: state_in = S_REPLY;
         S_REPLY: begin
            if (stat.out_free) begin
               state_in = stat.req_valid ? S_DECODE : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      ctrl = '0;
      ctrl.res_code = ST_OK;
      case (state_ff)
         S_IDLE: ctrl.req_ready = 1'b1;
         S_DECODE: begin
            case (stat.command)
               CMD_SPAWN: begin
                  if (!stat.asset_valid) begin
                     ctrl.set_result = 1'b1;
                     ctrl.res_code   = ST_BAD_ASSET;
                  end else if (!stat.stack_empty) begin
                     ctrl.stack_pop = 1'b1;
                  end else if (!stat.table_full) begin
                     ctrl.spawn_new = 1'b1;
                  end else begin
                     ctrl.set_result = 1'b1;
                     ctrl.res_code   = ST_FULL;
                  end
               end
               CMD_DESPAWN, CMD_CHECK: begin
                  if (stat.in_range) begin
                     ctrl.tbl_rd_handle = 1'b1;
                  end else begin
                     ctrl.set_result = 1'b1;
                     ctrl.res_code   = ST_STALE;
                  end
               end
               default: begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_code   = ST_STALE;
               end
            endcase
         end
         S_STACK: ctrl.tbl_rd_stack = 1'b1;
         S_TABLE: begin
            case (stat.command)
               CMD_SPAWN: ctrl.spawn_reuse = 1'b1;
               CMD_DESPAWN: begin
                  if (stat.handle_match) begin
                     ctrl.release_slot = 1'b1;
                  end else begin
                     ctrl.set_result = 1'b1;
                     ctrl.res_code   = ST_STALE;
                  end
               end
               default: begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_code   = stat.handle_match ? ST_OK : ST_STALE;
               end
            endcase
         end
         S_REPLY: begin
            ctrl.out_load  = stat.out_free;
            ctrl.req_ready = stat.out_free;
         end
         default: ctrl = '0;
      endcase
   end

endmodule

FILE: hw/rtl/gsa_datapath.sv
module gsa_datapath #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   gsa_req_if.sink               req_chan,
   gsa_rsp_if.source             rsp_chan,
   input  gsa_pkg::gsa_ctrl_type ctrl,
   output gsa_pkg::gsa_stat_type stat
);
   import gsa_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CW     = (CNT_W > SLOT_FIELD_W) ? CNT_W : SLOT_FIELD_W;
   localparam int GW     = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;

   // latched request
   gsa_req_type req_q_ff;

   // handle table: alive mark over generation
   logic [GEN_BITS:0] tbl_mem [SLOTS];
   logic [GEN_BITS:0] tbl_q_ff;
   logic [SLOT_W-1:0] stack_mem [SLOTS];
   logic [SLOT_W-1:0] stack_q_ff;
   logic [SLOT_W-1:0] target_ff;

   // counters
   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] slots_used_ff, slots_used_in;
   logic [REV_W-1:0] rev_ff, rev_in;

   // result registers
   gsa_status_type      res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [GEN_BITS-1:0] res_gen_ff, res_gen_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   gsa_rsp_type rsp_data_ff;

   logic                req_take;
   logic                out_free;
   logic [CW-1:0]       hslot_ext;
   logic [SLOT_W-1:0]   handle_addr;
   logic [SLOT_W-1:0]   new_addr;
   logic [CNT_W-1:0]    cnt_dec;
   logic [SLOT_W-1:0]   pop_idx;
   logic [SLOT_W-1:0]   push_idx;
   logic                push_ok;
   logic [GEN_BITS-1:0] tbl_gen;
   logic                tbl_alive;
   logic                gen_match;
   logic                tbl_rd_en;
   logic [SLOT_W-1:0]   tbl_rd_addr;
   logic                tbl_wr_en;
   logic [SLOT_W-1:0]   tbl_wr_addr;
   logic [GEN_BITS:0]   tbl_wr_data;
   logic                stack_push;
   logic [SLOT_FIELD_W-1:0] slot_field;
   logic [GEN_FIELD_W-1:0]  gen_field;

   // handshake and address decode
   always_comb begin
      req_take    = req_chan.valid && ctrl.req_ready;
      out_free    = !rsp_valid_ff || rsp_chan.ready;
      hslot_ext   = CW'(req_q_ff.handle_slot);
      handle_addr = hslot_ext[SLOT_W-1:0];
      new_addr    = slots_used_ff[SLOT_W-1:0];
      cnt_dec     = free_count_ff - CNT_W'(1);
      pop_idx     = cnt_dec[SLOT_W-1:0];
      push_idx    = free_count_ff[SLOT_W-1:0];
      push_ok     = free_count_ff != CNT_W'(SLOTS);
      tbl_gen     = tbl_q_ff[GEN_BITS-1:0];
      tbl_alive   = tbl_q_ff[GEN_BITS];
      gen_match   = GW'(tbl_gen) == GW'(req_q_ff.handle_generation);
   end

   // status to controller
   always_comb begin
      stat.req_valid    = req_chan.valid;
      stat.command      = req_q_ff.command;
      stat.asset_valid  = req_q_ff.asset_valid;
      stat.stack_empty  = free_count_ff == '0;
      stat.table_full   = slots_used_ff == CNT_W'(SLOTS);
      stat.in_range     = hslot_ext < CW'(slots_used_ff);
      stat.handle_match = tbl_alive && gen_match;
      stat.out_free     = out_free;
   end

   // request latch
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_q_ff <= req_chan.payload;
      end
   end

   // table access control
   always_comb begin
      tbl_rd_en   = ctrl.tbl_rd_handle || ctrl.tbl_rd_stack;
      tbl_rd_addr = ctrl.tbl_rd_stack ? stack_q_ff : handle_addr;
      tbl_wr_en   = ctrl.spawn_new || ctrl.spawn_reuse || ctrl.release_slot;
      tbl_wr_addr = ctrl.spawn_new ? new_addr : target_ff;
      if (ctrl.spawn_new) begin
         tbl_wr_data = {1'b1, {GEN_BITS{1'b0}}};
      end else if (ctrl.spawn_reuse) begin
         tbl_wr_data = {1'b1, tbl_gen};
      end else begin
         tbl_wr_data = {1'b0, tbl_gen + GEN_BITS'(1)};
      end
      stack_push = ctrl.release_slot && push_ok;
   end

   // handle table memory
   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         tbl_mem[tbl_wr_addr] <= tbl_wr_data;
      end
      if (tbl_rd_en) begin
         tbl_q_ff  <= tbl_mem[tbl_rd_addr];
         target_ff <= tbl_rd_addr;
      end
   end

   // free stack memory
   always_ff @(posedge clock) begin
      if (stack_push) begin
         stack_mem[push_idx] <= target_ff;
      end
      if (ctrl.stack_pop) begin
         stack_q_ff <= stack_mem[pop_idx];
      end
   end

   // counter updates
   always_comb begin
      free_count_in = free_count_ff;
      slots_used_in = slots_used_ff;
      rev_in        = rev_ff;
      if (ctrl.stack_pop) begin
         free_count_in = cnt_dec;
      end else if (stack_push) begin
         free_count_in = free_count_ff + CNT_W'(1);
      end
      if (ctrl.spawn_new) begin
         slots_used_in = slots_used_ff + CNT_W'(1);
      end
      if (ctrl.spawn_new || ctrl.spawn_reuse || ctrl.release_slot) begin
         rev_in = rev_ff + REV_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         slots_used_ff <= '0;
         rev_ff        <= '0;
      end else begin
         free_count_ff <= free_count_in;
         slots_used_ff <= slots_used_in;
         rev_ff        <= rev_in;
      end
   end

   // result selection
   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_gen_in    = res_gen_ff;
      if (ctrl.spawn_new) begin
         res_status_in = ST_OK;
         res_slot_in   = new_addr;
         res_gen_in    = '0;
      end else if (ctrl.spawn_reuse) begin
         res_status_in = ST_OK;
         res_slot_in   = target_ff;
         res_gen_in    = tbl_gen;
      end else if (ctrl.release_slot) begin
         res_status_in = ST_OK;
         res_slot_in   = '0;
         res_gen_in    = '0;
      end else if (ctrl.set_result) begin
         res_status_in = ctrl.res_code;
         res_slot_in   = '0;
         res_gen_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_gen_ff    <= res_gen_in;
   end

   // response register, frees the worker while a response waits
   always_comb begin
      slot_field   = SLOT_FIELD_W'(res_slot_ff);
      gen_field    = GEN_FIELD_W'(res_gen_ff);
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_data_ff.status         <= res_status_ff;
         rsp_data_ff.slot_out       <= slot_field;
         rsp_data_ff.generation_out <= gen_field;
         rsp_data_ff.revision       <= rev_ff;
      end
   end

   assign req_chan.ready   = ctrl.req_ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule

FILE: hw/rtl/generational_slot_allocator_unit.sv
// Generational slot allocator: hands out (slot, generation) handles and checks them.
// req_chan carries one request (spawn, despawn or check); rsp_chan returns exactly
// one response per request, in order, with status, granted slot and generation,
// and the revision count after that request. Both use valid/ready.
// Steps per request, from acceptance to response valid: decode then reply for spawns
// of a never-used slot and rejected requests, one table read between for despawn and
// check, and a free stack read, then a table read, for a spawn that reuses a freed slot.
// The next request is taken in the cycle the response register is loaded; the
// sequencer works on one request at a time, with the table and free stack reads
// done one after the other.
// Reset is synchronous: counters, the revision and the response valid flag clear
// at once; the table needs no clearing pass because only slots below the
// used-slot count are ever read and each is written when first granted.
// When the receiver stalls the response is held in the output register and the
// block finishes its next request, then waits with that result until it drains.
module generational_slot_allocator_unit #(
   parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
   parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   gsa_req_if.sink   req_chan,
   gsa_rsp_if.source rsp_chan
);
   import gsa_pkg::*;

   gsa_ctrl_type ctrl;
   gsa_stat_type stat;

   // sequencer
   gsa_controller u_controller (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // table, free stack, counters and response register
   gsa_datapath #(
      .SLOTS    (SLOTS),
      .GEN_BITS (GEN_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .ctrl     (ctrl),
      .stat     (stat)
   );

endmodule

FILE: dv/generational_slot_allocator_unit_tb.sv
module generational_slot_allocator_unit_tb;
   import gsa_pkg::*;

   localparam int TABLE_SLOTS = SLOTS_DEF;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PCT    = 21;
   localparam int DIR_ROWS    = 20;

   // the encoding the command enum leaves unused
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic                    asset_valid;
      logic [SLOT_FIELD_W-1:0] handle_slot;
      logic [GEN_FIELD_W-1:0]  handle_generation;
      logic                    typed;
      gsa_rsp_type             want;
   } stim_row_type;

   logic clock;
   logic reset;

   gsa_req_if req_if ();
   gsa_rsp_if rsp_if ();

   generational_slot_allocator_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // shadow copy of the handle table
   bit                    alive_of   [TABLE_SLOTS];
   bit [GEN_FIELD_W-1:0]  gen_of     [TABLE_SLOTS];
   bit [SLOT_FIELD_W-1:0] free_slots [TABLE_SLOTS];
   int                    free_cnt;
   int                    used_cnt;
   bit [REV_W-1:0]        rev_cnt;
   int                    live_slots [$];

   gsa_rsp_type expected_q [$];
   int          fails;
   bit          steady_run;
   bit          hold_req;

   // directed requests; typed rows carry a fixed expectation
   stim_row_type dir_rows [DIR_ROWS] = '{
      // never-used slot right after reset
      '{CMD_CHECK,    1'b0, 10'd0,     16'd0,     1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd0}},
      '{CMD_DESPAWN,  1'b1, 10'd0,     16'd0,     1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd0}},
      // bad asset, reserved command
      '{CMD_SPAWN,    1'b0, 10'h3FF,   16'hFFFF,  1'b1, '{ST_BAD_ASSET, 10'd0, 16'd0, 32'd0}},
      '{CMD_RESERVED, 1'b1, 10'h3FF,   16'hFFFF,  1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd0}},
      // first grant, handle fields ignored on spawn
      '{CMD_SPAWN,    1'b1, 10'h3FF,   16'hFFFF,  1'b1, '{ST_OK, 10'd0, 16'd0, 32'd1}},
      '{CMD_SPAWN,    1'b1, 10'd0,     16'd0,     1'b0, '0},
      '{CMD_CHECK,    1'b0, 10'd0,     16'd0,     1'b0, '0},
      // generation mismatch
      '{CMD_CHECK,    1'b1, 10'd0,     16'd1,     1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd2}},
      '{CMD_CHECK,    1'b0, 10'h3FF,   16'hFFFF,  1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd2}},
      // asset_valid ignored on despawn
      '{CMD_DESPAWN,  1'b0, 10'd0,     16'd0,     1'b0, '0},
      // dead slot
      '{CMD_CHECK,    1'b0, 10'd0,     16'd0,     1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd3}},
      '{CMD_DESPAWN,  1'b1, 10'd0,     16'd0,     1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd3}},
      // reuse from the free stack, lifo order
      '{CMD_SPAWN,    1'b1, 10'd0,     16'd0,     1'b0, '0},
      '{CMD_DESPAWN,  1'b1, 10'd1,     16'd0,     1'b0, '0},
      '{CMD_DESPAWN,  1'b0, 10'd0,     16'd1,     1'b0, '0},
      '{CMD_SPAWN,    1'b1, 10'd0,     16'd0,     1'b0, '0},
      '{CMD_SPAWN,    1'b1, 10'd0,     16'd0,     1'b0, '0},
      '{CMD_SPAWN,    1'b1, 10'd0,     16'd0,     1'b0, '0},
      '{CMD_DESPAWN,  1'b1, 10'd2,     16'd0,     1'b0, '0},
      '{CMD_CHECK,    1'b1, 10'd2,     16'hFFFF,  1'b1, '{ST_STALE, 10'd0, 16'd0, 32'd10}}
   };

   function automatic bit handle_live(input logic [SLOT_FIELD_W-1:0] slot,
                                      input logic [GEN_FIELD_W-1:0] gen);
      if (int'(slot) >= used_cnt)
         return 1'b0;
      return alive_of[slot] && (gen_of[slot] == gen);
   endfunction

   // apply one request to the shadow table and return the response it yields
   function automatic gsa_rsp_type table_update(input gsa_req_type r);
      gsa_rsp_type           res;
      bit [SLOT_FIELD_W-1:0] s;
      res = '0;
      case (r.command)
         CMD_SPAWN: begin
            if (!r.asset_valid) begin
               res.status = ST_BAD_ASSET;
            end else if (free_cnt > 0 || used_cnt < TABLE_SLOTS) begin
               if (free_cnt > 0) begin
                  free_cnt--;
                  s = free_slots[free_cnt];
               end else begin
                  s = used_cnt[SLOT_FIELD_W-1:0];
                  used_cnt++;
               end
               alive_of[s] = 1'b1;
               rev_cnt++;
               live_slots = {live_slots, int'(s)};
               res.status         = ST_OK;
               res.slot_out       = s;
               res.generation_out = gen_of[s];
            end else begin
               res.status = ST_FULL;
            end
         end
         CMD_DESPAWN: begin
            if (handle_live(r.handle_slot, r.handle_generation)) begin
               s = r.handle_slot;
               alive_of[s] = 1'b0;
               gen_of[s]   = gen_of[s] + 1'b1;
               if (free_cnt < TABLE_SLOTS) begin
                  free_slots[free_cnt] = s;
                  free_cnt++;
               end
               rev_cnt++;
               for (int k = 0; k < live_slots.size(); k++) begin
                  if (live_slots[k] == int'(s)) begin
                     live_slots.delete(k);
                     break;
                  end
               end
               res.status = ST_OK;
            end else begin
               res.status = ST_STALE;
            end
         end
         CMD_CHECK: begin
            res.status = handle_live(r.handle_slot, r.handle_generation) ? ST_OK : ST_STALE;
         end
         default: begin
            res.status = ST_STALE;
         end
      endcase
      res.revision = rev_cnt;
      return res;
   endfunction

   // handle for despawn or check: mostly live ones, some near misses and noise
   function automatic void fill_handle(inout gsa_req_type r);
      int form;
      int s;
      form = $urandom_range(0, 9);
      if (form <= 7 && live_slots.size() > 0) begin
         s = live_slots[$urandom_range(0, live_slots.size() - 1)];
         r.handle_slot       = s[SLOT_FIELD_W-1:0];
         r.handle_generation = gen_of[s];
         if (form == 7)
            r.handle_generation = gen_of[s] ^ (16'd1 << $urandom_range(0, 15));
      end else if (form == 8 && used_cnt > 0) begin
         // earlier generation of a used slot
         s = $urandom_range(0, used_cnt - 1);
         r.handle_slot       = s[SLOT_FIELD_W-1:0];
         r.handle_generation = gen_of[s] - 1'b1;
      end
   endfunction

   function automatic gsa_req_type pick_request(input int spawn_pct, input int despawn_pct);
      gsa_req_type r;
      int          roll;
      r.command           = CMD_RESERVED;
      r.asset_valid       = 1'($urandom_range(0, 1));
      r.handle_slot       = SLOT_FIELD_W'($urandom);
      r.handle_generation = GEN_FIELD_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < spawn_pct) begin
         r.command     = CMD_SPAWN;
         r.asset_valid = ($urandom_range(0, 19) != 0);
      end else if (roll < spawn_pct + despawn_pct) begin
         r.command = CMD_DESPAWN;
         fill_handle(r);
      end else if (roll < 95) begin
         r.command = CMD_CHECK;
         fill_handle(r);
      end else begin
         r.command = CMD_W'($urandom_range(0, 3));
      end
      return r;
   endfunction

   // offer one request, wait for the handshake, record what must come back
   task automatic send_request(input gsa_req_type r, input bit typed,
                               input gsa_rsp_type want);
      gsa_rsp_type predicted;
      if (!steady_run) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      predicted = table_update(r);
      expected_q = {expected_q, typed ? want : predicted};
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic check_response(input gsa_rsp_type got);
      gsa_rsp_type want;
      if (expected_q.size() == 0) begin
         $error("response with no request pending: status %0d revision %0d",
                got.status, got.revision);
         fails++;
         return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         fails++;
      end
      if (got.slot_out !== want.slot_out) begin
         $error("slot_out expected %0d actual %0d", want.slot_out, got.slot_out);
         fails++;
      end
      if (got.generation_out !== want.generation_out) begin
         $error("generation_out expected %0d actual %0d", want.generation_out,
                got.generation_out);
         fails++;
      end
      if (got.revision !== want.revision) begin
         $error("revision expected %0d actual %0d", want.revision, got.revision);
         fails++;
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response side: random backpressure plus one long hold-off on demand
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            check_response(rsp_if.payload);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // request side
   initial begin
      gsa_req_type r;
      fails      = 0;
      steady_run = 1'b0;
      hold_req   = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         r.command           = dir_rows[i].command;
         r.asset_valid       = dir_rows[i].asset_valid;
         r.handle_slot       = dir_rows[i].handle_slot;
         r.handle_generation = dir_rows[i].handle_generation;
         send_request(r, dir_rows[i].typed, dir_rows[i].want);
      end
      wait_drained();

      // mixed traffic with no idling on either side
      steady_run = 1'b1;
      for (int i = 0; i < 300; i++)
         send_request(pick_request(70, 15), 1'b0, '0);
      steady_run = 1'b0;

      // spawn heavy until the table runs full, with one long receiver hold-off
      for (int i = 0; i < 1100; i++) begin
         if (i == 500)
            hold_req = 1'b1;
         send_request(pick_request(96, 1), 1'b0, '0);
      end
      wait_drained();

      // drain heavy, stack reuse in lifo order
      for (int i = 0; i < 400; i++) begin
         if (i == 100)
            hold_req = 1'b1;
         send_request(pick_request(15, 60), 1'b0, '0);
      end

      // let everything come back, then watch for stray responses
      wait_drained();
      repeat (8) @(posedge clock);
      if (fails == 0 && expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_req_if.sv
hw/rtl/gsa_rsp_if.sv
hw/rtl/gsa_controller.sv
hw/rtl/gsa_datapath.sv
hw/rtl/generational_slot_allocator_unit.sv
dv/generational_slot_allocator_unit_tb.sv
